/* src/prd_pkg.sv */
// Shared types and constants for the proxy record deframer.
package prd_pkg;

   localparam int unsigned HdrLast      = 13;
   localparam logic [15:0] LenOverhead  = 16'd12;
   localparam logic [15:0] TypeData     = 16'd5;
   localparam logic [15:0] TypeSkipA    = 16'd4;
   localparam logic [15:0] TypeSkipB    = 16'd7;
   localparam logic [15:0] VersionReset = 16'h0443;

   localparam int unsigned QueueDepth   = 4;
   localparam int unsigned QueuePtrW    = $clog2(QueueDepth);

   typedef enum logic [0:0] {
      CSR_PROTOCOL_VERSION = 1'b0,
      CSR_SOCKET_ID        = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_BAD_LENGTH  = 2'd0,
      ERR_BAD_VERSION = 2'd1,
      ERR_BAD_TYPE    = 2'd2,
      ERR_TRUNCATED   = 2'd3
   } err_code_type;

   typedef enum logic [2:0] {
      MODE_HEADER  = 3'b001,
      MODE_PAYLOAD = 3'b010,
      MODE_ERROR   = 3'b100
   } mode_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       error_valid;
      logic [1:0] error_code;
      logic       response_done;
   } rsp_type;

endpackage

/* src/prd_req_if.sv */
// Request channel: one response body byte with its remaining count.
interface prd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [23:0] bytes_left;

   modport source (output valid, output rx_byte, output bytes_left, input ready);
   modport sink   (input valid, input rx_byte, input bytes_left, output ready);
endinterface

/* src/prd_rsp_if.sv */
// Response channel: forwarded payload byte, error report or end of response.
interface prd_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       error_valid;
   logic [1:0] error_code;
   logic       response_done;

   modport source (output valid, output payload_valid, output payload_byte,
                   output error_valid, output error_code, output response_done,
                   input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input error_valid, input error_code, input response_done,
                   output ready);
endinterface

/* src/prd_parser.sv */
// Front end: accepts body bytes, tracks record framing, classifies each byte.
module prd_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic [23:0]       in_left,
   input  logic              queue_full,
   output logic              push,
   output prd_pkg::rsp_type  push_data
);
   import prd_pkg::*;

   logic [15:0] version_ff, socket_ff;
   logic [3:0]  header_count_ff, header_count_in;
   logic [15:0] rec_length_ff, rec_length_in;
   logic [15:0] rec_version_ff, rec_version_in;
   logic [15:0] rec_type_ff, rec_type_in;
   logic [15:0] rec_socket_ff, rec_socket_in;
   logic [15:0] payload_left_ff, payload_left_in;
   mode_type    mode_ff, mode_in;
   logic        forward_ff, forward_in;

   logic        accept;
   logic        last;
   logic [23:0] after;
   logic [15:0] body_len;
   rsp_type     res;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign last     = (in_left <= 24'd1);
   assign after    = (in_left == 24'd0) ? 24'd0 : in_left - 24'd1;
   assign body_len = rec_length_in - LenOverhead;

   always_comb begin
      header_count_in = header_count_ff;
      rec_length_in   = rec_length_ff;
      rec_version_in  = rec_version_ff;
      rec_type_in     = rec_type_ff;
      rec_socket_in   = rec_socket_ff;
      payload_left_in = payload_left_ff;
      mode_in         = mode_ff;
      forward_in      = forward_ff;
      res             = '0;

      unique case (mode_ff)
         MODE_HEADER: begin
            if (header_count_ff < 4'd2) begin
               rec_length_in = {rec_length_ff[7:0], in_byte};
            end else if (header_count_ff < 4'd4) begin
               rec_version_in = {rec_version_ff[7:0], in_byte};
            end else if (header_count_ff < 4'd6) begin
               rec_type_in = {rec_type_ff[7:0], in_byte};
            end else if (header_count_ff >= 4'd12) begin
               rec_socket_in = {rec_socket_ff[7:0], in_byte};
            end

            if (header_count_ff >= 4'(HdrLast)) begin
               header_count_in = '0;
               if (rec_length_in < LenOverhead || {8'd0, body_len} > after) begin
                  res.error_valid = 1'b1;
                  res.error_code  = ERR_BAD_LENGTH;
               end else if (rec_version_in != version_ff) begin
                  res.error_valid = 1'b1;
                  res.error_code  = ERR_BAD_VERSION;
               end else if (rec_type_in != TypeData && rec_type_in != TypeSkipA &&
                            rec_type_in != TypeSkipB) begin
                  res.error_valid = 1'b1;
                  res.error_code  = ERR_BAD_TYPE;
               end else begin
                  payload_left_in = body_len;
                  forward_in      = (rec_type_in == TypeData) && (rec_socket_in == socket_ff);
                  mode_in         = (body_len != 16'd0) ? MODE_PAYLOAD : MODE_HEADER;
               end
            end else begin
               header_count_in = header_count_ff + 4'd1;
               if (last) begin
                  res.error_valid = 1'b1;
                  res.error_code  = ERR_TRUNCATED;
               end
            end
         end
         MODE_PAYLOAD: begin
            if (forward_ff) begin
               res.payload_valid = 1'b1;
               res.payload_byte  = in_byte;
            end
            payload_left_in = payload_left_ff - 16'd1;
            if (payload_left_in == 16'd0) begin
               mode_in = MODE_HEADER;
            end
         end
         default: begin
         end
      endcase

      if (res.error_valid) begin
         mode_in = MODE_ERROR;
      end

      if (last) begin
         res.response_done = !res.error_valid && (mode_ff != MODE_ERROR);
         mode_in           = MODE_HEADER;
         header_count_in   = '0;
         payload_left_in   = '0;
         forward_in        = 1'b0;
      end
   end

   assign push      = accept && (res.payload_valid || res.error_valid || res.response_done);
   assign push_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff      <= VersionReset;
         socket_ff       <= '0;
         header_count_ff <= '0;
         rec_length_ff   <= '0;
         rec_version_ff  <= '0;
         rec_type_ff     <= '0;
         rec_socket_ff   <= '0;
         payload_left_ff <= '0;
         mode_ff         <= MODE_HEADER;
         forward_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_PROTOCOL_VERSION: version_ff <= csr_wdata;
               CSR_SOCKET_ID:        socket_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            header_count_ff <= header_count_in;
            rec_length_ff   <= rec_length_in;
            rec_version_ff  <= rec_version_in;
            rec_type_ff     <= rec_type_in;
            rec_socket_ff   <= rec_socket_in;
            payload_left_ff <= payload_left_in;
            mode_ff         <= mode_in;
            forward_ff      <= forward_in;
         end
      end
   end

endmodule

/* src/prd_queue.sv */
// Short result queue between the parser and the output stage.
module prd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  prd_pkg::rsp_type  push_data,
   output logic              full,
   output logic              head_valid,
   output prd_pkg::rsp_type  head_data,
   input  logic              head_ready
);
   import prd_pkg::*;

   rsp_type                 mem [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrW:0]      count_ff, count_in;
   logic                    pop;

   assign full       = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem[rd_ptr_ff];
   assign pop        = head_valid && head_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

/* src/prd_emit.sv */
// Back end: output register that presents results on the response channel.
module prd_emit (
   input  logic              clock,
   input  logic              reset,
   input  prd_pkg::rsp_type  head_data,
   input  logic              head_valid,
   output logic              head_ready,
   prd_rsp_if.source         rsp_ch
);
   import prd_pkg::*;

   logic    out_valid_ff;
   rsp_type out_data_ff;

   assign head_ready = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (head_ready) begin
         out_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (head_ready && head_valid) begin
         out_data_ff <= head_data;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.payload_valid = out_data_ff.payload_valid;
   assign rsp_ch.payload_byte  = out_data_ff.payload_byte;
   assign rsp_ch.error_valid   = out_data_ff.error_valid;
   assign rsp_ch.error_code    = out_data_ff.error_code;
   assign rsp_ch.response_done = out_data_ff.response_done;

endmodule

/* src/proxy_record_deframer.sv */
// Top level of the proxy record deframer.
//
// Usage: req_ch carries one response body byte per transaction with the count
// of bytes left (1 marks the last byte). rsp_ch carries at most one result per
// byte: a forwarded payload byte of a matching data record, an error report,
// and/or response_done on the last byte of an error-free response. Bytes that
// cause no result (headers, skipped payloads, bytes after an error) produce no
// rsp_ch transaction.
// The csr port writes protocol_version (index 0) and socket_id (index 1); write
// it only while the block is idle.
// Throughput: one byte per clock while the queue is not full, set by the
// combinational framing update in the parser. With the queue empty, a result
// enters the queue on the edge that takes the byte, then the rsp_ch output register.
// A four-entry result queue and the output register let req_ch keep moving
// while rsp_ch is stalled; req_ch.ready drops only when the queue is full.
// Reset (synchronous) empties the queue, returns the parser to header mode and
// restores protocol_version to 0x0443 and socket_id to 0.
module proxy_record_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   prd_req_if.sink     req_ch,
   prd_rsp_if.source   rsp_ch
);
   import prd_pkg::*;

   logic     push;
   rsp_type  push_data;
   logic     queue_full;
   logic     head_valid;
   rsp_type  head_data;
   logic     head_ready;

   prd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_byte    (req_ch.rx_byte),
      .in_left    (req_ch.bytes_left),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   prd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_ready (head_ready)
   );

   prd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
